### src/seismic_event_trigger_defines.svh
// ----------------------------------------------------------------------------
// seismic_event_trigger_defines
// Assertion macros shared by the seismic event trigger modules.
// ----------------------------------------------------------------------------
`ifndef SEISMIC_EVENT_TRIGGER_DEFINES_SVH
`define SEISMIC_EVENT_TRIGGER_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SET_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("seismic_event_trigger: check failed");

// antecedent holds -> consequent holds in the next cycle
`define SET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("seismic_event_trigger: check failed");

`endif

### src/set_pkg.sv
// ----------------------------------------------------------------------------
// set_pkg
// Shared types, constants and register map of the seismic event trigger.
// ----------------------------------------------------------------------------
package set_pkg;

  localparam int WindowDefault = 64;

  localparam int SampleW  = 16;
  localparam int CntW     = 14;
  localparam int FeatW    = 30;
  localparam int ThrW     = 31;
  localparam int RunW     = 16;
  localparam int LearnW   = 44;
  localparam int GainW    = 8;
  localparam int ShiftW   = 5;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int RegIdxW  = 3;

  localparam logic [1:0] PhaseFill   = 2'd0;
  localparam logic [1:0] PhaseLearn  = 2'd1;
  localparam logic [1:0] PhaseDetect = 2'd2;

  localparam logic [RegIdxW-1:0] RegLearnLength  = 3'd0;
  localparam logic [RegIdxW-1:0] RegPreCount     = 3'd1;
  localparam logic [RegIdxW-1:0] RegTriggerCount = 3'd2;
  localparam logic [RegIdxW-1:0] RegDiffGain     = 3'd3;
  localparam logic [RegIdxW-1:0] RegLearnShift   = 3'd4;

  localparam logic [CntW-1:0]   LearnLengthRst  = 14'd1000;
  localparam logic [RunW-1:0]   PreCountRst     = 16'd6;
  localparam logic [RunW-1:0]   TriggerCountRst = 16'd50;
  localparam logic [GainW-1:0]  DiffGainRst     = 8'd100;
  localparam logic [ShiftW-1:0] LearnShiftRst   = 5'd9;

  typedef struct packed {
    logic [CntW-1:0]   learn_length;
    logic [RunW-1:0]   pre_count;
    logic [RunW-1:0]   trigger_count;
    logic [GainW-1:0]  diff_gain;
    logic [ShiftW-1:0] learn_shift;
  } set_cfg_t;

  typedef struct packed {
    logic feat_valid;
    logic detect;
  } set_tag_t;

endpackage

### src/seismic_event_trigger.sv
// An accepted sample passes the s1, s2 and s3 registers and then the output
// register of set_detect before its result beat is valid.
// Throughput: one sample per cycle unless out_ready_i stalls; the window
// memory has one write and one read port, prefetching the oldest sample.
// Reset: configuration returns to defaults, sums, counters and flags clear.
// The window memory is not cleared; slots not yet written read as zero
// through a wrap flag, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// seismic_event_trigger
// Per-sample seismic event trigger: windowed feature, learned threshold,
// run counting and event recording.
// ----------------------------------------------------------------------------
module seismic_event_trigger #(
  parameter int WINDOW = set_pkg::WindowDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [set_pkg::AddrW-1:0]          paddr,
  input  logic [set_pkg::DataW-1:0]          pwdata,
  output logic [set_pkg::DataW-1:0]          prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [set_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [set_pkg::FeatW-1:0]          feature_o,
  output logic                               feature_valid_o,
  output logic [1:0]                         phase_o,
  output logic [set_pkg::ThrW-1:0]           threshold_o,
  output logic [set_pkg::RunW-1:0]           run_length_o,
  output logic                               event_res_o,
  output logic                               recording_o
);

  localparam int AbsW  = $clog2(WINDOW * 32768 + 1);
  localparam int DiffW = $clog2(WINDOW * 65535 + 1);
  localparam int ProdW = DiffW + set_pkg::GainW;
  localparam int SumW  = ((AbsW > ProdW) ? AbsW : ProdW) + 1;
  localparam int CmpW  = (SumW > set_pkg::FeatW) ? SumW : set_pkg::FeatW;
  localparam int FW    = set_pkg::FeatW;

  set_pkg::set_cfg_t cfg;
  set_pkg::set_tag_t tag_w, s1_tag_q, s2_tag_q, s3_tag_q;
  logic [AbsW-1:0]   abs_w, s1_abs_q, s2_abs_q;
  logic [DiffW-1:0]  diff_w, s1_diff_q;
  logic [ProdW-1:0]  s2_prod_q;
  logic [FW-1:0]     s3_feat_q;
  logic [SumW-1:0]   feat_sum;
  logic [CmpW-1:0]   feat_ext;
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic              s1_rdy, s2_rdy, s3_rdy, det_rdy;
  logic              in_accept;

  set_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign s3_rdy     = !s3_v_q || det_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;
  assign in_accept  = in_valid_i && in_ready_o;

  set_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .sample_i      (sample_i),
    .learn_length_i(cfg.learn_length),
    .tag_o         (tag_w),
    .abs_sum_o     (abs_w),
    .diff_sum_o    (diff_w)
  );

  assign feat_sum = SumW'(s2_abs_q) + SumW'(s2_prod_q);
  assign feat_ext = CmpW'(feat_sum);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tag_q  <= tag_w;
      s1_abs_q  <= abs_w;
      s1_diff_q <= diff_w;
    end
    if (s2_rdy && s1_v_q) begin
      s2_tag_q  <= s1_tag_q;
      s2_abs_q  <= s1_abs_q;
      s2_prod_q <= ProdW'(s1_diff_q) * ProdW'(cfg.diff_gain);
    end
    if (s3_rdy && s2_v_q) begin
      s3_tag_q  <= s2_tag_q;
      s3_feat_q <= (feat_ext > CmpW'({FW{1'b1}})) ? '1 : feat_ext[FW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  set_detect u_detect (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s3_v_q),
    .ready_o        (det_rdy),
    .tag_i          (s3_tag_q),
    .feat_i         (s3_feat_q),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .feature_o      (feature_o),
    .feature_valid_o(feature_valid_o),
    .phase_o        (phase_o),
    .threshold_o    (threshold_o),
    .run_length_o   (run_length_o),
    .event_res_o    (event_res_o),
    .recording_o    (recording_o)
  );

endmodule

### src/set_cfg.sv
// ----------------------------------------------------------------------------
// set_cfg
// APB register file holding the trigger configuration.
// ----------------------------------------------------------------------------
module set_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [set_pkg::AddrW-1:0] paddr,
  input  logic [set_pkg::DataW-1:0] pwdata,
  output logic [set_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output set_pkg::set_cfg_t        cfg_o
);

  set_pkg::set_cfg_t             cfg_q, cfg_d;
  logic [set_pkg::RegIdxW-1:0]   idx;
  logic                          wr;

  assign pready = 1'b1;
  assign idx    = paddr[set_pkg::AddrW-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        set_pkg::RegLearnLength:  cfg_d.learn_length  = pwdata[set_pkg::CntW-1:0];
        set_pkg::RegPreCount:     cfg_d.pre_count     = pwdata[set_pkg::RunW-1:0];
        set_pkg::RegTriggerCount: cfg_d.trigger_count = pwdata[set_pkg::RunW-1:0];
        set_pkg::RegDiffGain:     cfg_d.diff_gain     = pwdata[set_pkg::GainW-1:0];
        set_pkg::RegLearnShift:   cfg_d.learn_shift   = pwdata[set_pkg::ShiftW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      set_pkg::RegLearnLength:  prdata = set_pkg::DataW'(cfg_q.learn_length);
      set_pkg::RegPreCount:     prdata = set_pkg::DataW'(cfg_q.pre_count);
      set_pkg::RegTriggerCount: prdata = set_pkg::DataW'(cfg_q.trigger_count);
      set_pkg::RegDiffGain:     prdata = set_pkg::DataW'(cfg_q.diff_gain);
      set_pkg::RegLearnShift:   prdata = set_pkg::DataW'(cfg_q.learn_shift);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_length  <= set_pkg::LearnLengthRst;
      cfg_q.pre_count     <= set_pkg::PreCountRst;
      cfg_q.trigger_count <= set_pkg::TriggerCountRst;
      cfg_q.diff_gain     <= set_pkg::DiffGainRst;
      cfg_q.learn_shift   <= set_pkg::LearnShiftRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/set_window.sv
// ----------------------------------------------------------------------------
// set_window
// Sample window memory with prefetched read of the oldest sample, running
// absolute and difference sums, and the sample counter.
// ----------------------------------------------------------------------------
`include "seismic_event_trigger_defines.svh"

module set_window #(
  parameter int WINDOW = set_pkg::WindowDefault,
  localparam int Slots = WINDOW + 1,
  localparam int PtrW  = $clog2(Slots),
  localparam int AbsW  = $clog2(WINDOW * 32768 + 1),
  localparam int DiffW = $clog2(WINDOW * 65535 + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [set_pkg::SampleW-1:0] sample_i,
  input  logic [set_pkg::CntW-1:0]           learn_length_i,
  output set_pkg::set_tag_t                  tag_o,
  output logic [AbsW-1:0]                    abs_sum_o,
  output logic [DiffW-1:0]                   diff_sum_o
);

  localparam int SW = set_pkg::SampleW;
  localparam int CW = set_pkg::CntW;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] a);
    return (a == PtrW'(Slots - 1)) ? '0 : a + PtrW'(1);
  endfunction

  function automatic logic [SW-1:0] absdiff(input logic signed [SW-1:0] a,
                                            input logic signed [SW-1:0] b);
    logic signed [SW+1:0] d;
    d = {{2{a[SW-1]}}, a} - {{2{b[SW-1]}}, b};
    return d[SW+1] ? SW'(-d) : d[SW-1:0];
  endfunction

  logic signed [SW-1:0] mem [Slots];
  logic signed [SW-1:0] rdata_q;
  logic [PtrW-1:0]      wp_q, wp_d, ra_cur, ra_d;
  logic                 wrapped_q, wrapped_d;
  logic signed [SW-1:0] pred_q, prev_q, old_first;
  logic [AbsW-1:0]      abs_q, abs_d;
  logic [DiffW-1:0]     diff_q, diff_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rd_ok;

  assign ra_cur    = nxt(wp_q);
  assign wp_d      = accept_i ? nxt(wp_q) : wp_q;
  assign ra_d      = accept_i ? nxt(wp_d) : ra_cur;
  assign wrapped_d = wrapped_q || (accept_i && (wp_q == PtrW'(Slots - 1)));
  // entries ahead of the write pointer read as zero until the first wrap
  assign rd_ok     = wrapped_q || (ra_cur < wp_q);
  assign old_first = rd_ok ? rdata_q : '0;

  assign abs_d  = abs_q - AbsW'(absdiff(old_first, '0)) + AbsW'(absdiff(sample_i, '0));
  assign diff_d = diff_q - DiffW'(absdiff(old_first, pred_q))
                + DiffW'(absdiff(sample_i, prev_q));
  assign cnt_d  = (cnt_q == '1) ? cnt_q : cnt_q + CW'(1);

  assign tag_o.feat_valid = (cnt_q >= CW'(WINDOW - 1));
  assign tag_o.detect     = ({1'b0, cnt_q} + (CW + 1)'(1)) >= {1'b0, learn_length_i};
  assign abs_sum_o        = abs_d;
  assign diff_sum_o       = diff_d;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[wp_q] <= sample_i;
    end
    rdata_q <= mem[ra_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      pred_q    <= '0;
      prev_q    <= '0;
      abs_q     <= '0;
      diff_q    <= '0;
      cnt_q     <= '0;
    end else if (accept_i) begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      pred_q    <= old_first;
      prev_q    <= sample_i;
      abs_q     <= abs_d;
      diff_q    <= diff_d;
      cnt_q     <= cnt_d;
    end
  end

  `SET_ASSERT_IMPLIES(a_no_rw_same_entry, accept_i, ra_d != wp_q)
  `SET_ASSERT_NEXT(a_valid_sticky, tag_o.feat_valid, tag_o.feat_valid)
  `SET_ASSERT_IMPLIES(a_wp_in_range, 1'b1, wp_q <= PtrW'(Slots - 1))

endmodule

### src/set_detect.sv
// ----------------------------------------------------------------------------
// set_detect
// Learning sum, threshold, run counter and recording flag; holds the result
// beat in the output register.
// ----------------------------------------------------------------------------
`include "seismic_event_trigger_defines.svh"

module set_detect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  set_pkg::set_tag_t              tag_i,
  input  logic [set_pkg::FeatW-1:0]      feat_i,
  input  set_pkg::set_cfg_t              cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [set_pkg::FeatW-1:0]      feature_o,
  output logic                           feature_valid_o,
  output logic [1:0]                     phase_o,
  output logic [set_pkg::ThrW-1:0]       threshold_o,
  output logic [set_pkg::RunW-1:0]       run_length_o,
  output logic                           event_res_o,
  output logic                           recording_o
);

  localparam int LW = set_pkg::LearnW;
  localparam int TW = set_pkg::ThrW;
  localparam int RW = set_pkg::RunW;
  localparam int FW = set_pkg::FeatW;

  logic              take;
  logic              out_v_q;
  logic [LW-1:0]     learn_q, learn_d, shifted;
  logic [LW:0]       learn_sum;
  logic [TW-1:0]     thr, thr_q, thr_d;
  logic [RW-1:0]     run_q, run_d, run_inc, need;
  logic              rec_q, rec_d, rec_set, ev, ev_q, ge;
  logic [FW-1:0]     feat_q, feat_d;
  logic              fv_q;
  logic [1:0]        phase_q, phase_d;
  logic              learn_item, detect_item;

  assign ready_o = !out_v_q || out_ready_i;
  assign take    = valid_i && ready_o;

  assign learn_item  = tag_i.feat_valid && !tag_i.detect;
  assign detect_item = tag_i.feat_valid && tag_i.detect;

  assign shifted   = learn_q >> cfg_i.learn_shift;
  assign thr       = (|shifted[LW-1:TW]) ? '1 : shifted[TW-1:0];
  assign ge        = {1'b0, feat_i} >= thr;
  assign run_inc   = (run_q == '1) ? run_q : run_q + RW'(1);
  assign need      = (cfg_i.pre_count > cfg_i.trigger_count) ? cfg_i.pre_count
                                                           : cfg_i.trigger_count;
  assign learn_sum = {1'b0, learn_q} + (LW + 1)'(feat_i);

  always_comb begin
    learn_d = learn_q;
    run_d   = run_q;
    rec_d   = rec_q;
    ev      = 1'b0;
    rec_set = rec_q;
    thr_d   = '0;
    feat_d  = tag_i.feat_valid ? feat_i : '0;
    phase_d = set_pkg::PhaseFill;
    if (learn_item) begin
      phase_d = set_pkg::PhaseLearn;
      learn_d = learn_sum[LW] ? '1 : learn_sum[LW-1:0];
    end else if (detect_item) begin
      phase_d = set_pkg::PhaseDetect;
      thr_d   = thr;
      run_d   = ge ? run_inc : '0;
      ev      = !rec_q && (run_d != '0) && (run_d >= need);
      rec_set = rec_q || ev;
      rec_d   = rec_set && !({1'b0, feat_i} <= (thr >> 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      feat_q  <= feat_d;
      fv_q    <= tag_i.feat_valid;
      phase_q <= phase_d;
      thr_q   <= thr_d;
      ev_q    <= ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      learn_q <= '0;
      run_q   <= '0;
      rec_q   <= 1'b0;
    end else begin
      if (ready_o) begin
        out_v_q <= valid_i;
      end
      if (take) begin
        learn_q <= learn_d;
        run_q   <= run_d;
        rec_q   <= rec_d;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign feature_o       = feat_q;
  assign feature_valid_o = fv_q;
  assign phase_o         = phase_q;
  assign threshold_o     = thr_q;
  assign run_length_o    = run_q;
  assign event_res_o     = ev_q;
  assign recording_o     = rec_q;

  `SET_ASSERT_IMPLIES(a_event_needs_idle_rec, take && ev, !rec_q)
  `SET_ASSERT_IMPLIES(a_event_only_detect, take && ev, detect_item && (run_d != '0))
  `SET_ASSERT_IMPLIES(a_learn_no_run_change, take && !detect_item,
                      (run_d == run_q) && (rec_d == rec_q))

endmodule

### sim/seismic_event_trigger_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seismic_event_trigger_tb
// Drives signed samples into the trigger and compares every result beat with a
// local prediction of the windowed feature, the learned threshold, the run
// counter and the event/recording flags. Both stream sides idle at random.
// Registers are set over APB between phases and read back.
// ----------------------------------------------------------------------------
module seismic_event_trigger_tb;
  import set_pkg::*;

  localparam int WINDOW = WindowDefault;
  localparam int SLOTS = WINDOW + 1;
  localparam int CLK_PERIOD = 10;
  localparam int unsigned COUNT_MAX = 16383;
  localparam longint unsigned LEARN_MAX = 64'h0000_0FFF_FFFF_FFFF;
  localparam longint unsigned THR_MAX = 64'h7FFF_FFFF;
  localparam longint unsigned FEAT_MAX = 64'h3FFF_FFFF;
  localparam int unsigned RUN_MAX = 65535;
  localparam logic [RegIdxW-1:0] RegUnused = 3'd5;
  localparam int RANDOM_BEATS = 800;
  localparam int LONG_RUN_BEATS = 150;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_LIMIT = 50000;
  localparam int MAX_REPORTS = 100;
  localparam int TIMEOUT_NS = 10_000_000;

  typedef struct packed {
    logic [FeatW-1:0] feature;
    logic             feature_valid;
    logic [1:0]       phase;
    logic [ThrW-1:0]  threshold;
    logic [RunW-1:0]  run_length;
    logic             event_res;
    logic             recording;
  } trig_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic out_valid_o, out_ready_i;
  logic [FeatW-1:0] feature_o;
  logic feature_valid_o;
  logic [1:0] phase_o;
  logic [ThrW-1:0] threshold_o;
  logic [RunW-1:0] run_length_o;
  logic event_res_o, recording_o;

  // predictor state
  set_cfg_t cfg;
  int win_mem [SLOTS];
  int unsigned win_ptr;
  longint unsigned abs_total, diff_total, learn_total;
  int unsigned samples_seen, thr_level, run_len;
  bit rec_on;

  trig_beat_t expected_beats[$];
  trig_beat_t got_beat, want_beat;
  longint unsigned recent_feature;
  int mismatch_count = 0;
  bit tx_idle_en, rx_idle_en;
  int rx_hold_id = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  seismic_event_trigger u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .feature_o      (feature_o),
    .feature_valid_o(feature_valid_o),
    .phase_o        (phase_o),
    .threshold_o    (threshold_o),
    .run_length_o   (run_length_o),
    .event_res_o    (event_res_o),
    .recording_o    (recording_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned abs_dist(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic trig_beat_t step_trigger(input int s);
    int unsigned p, i, need;
    int old_pred, old_first, prev;
    longint unsigned feat, t;
    bit valid;
    trig_beat_t r;
    r = '0;
    p = win_ptr;
    old_pred = win_mem[p];
    old_first = win_mem[(p + 1) % SLOTS];
    prev = win_mem[(p + WINDOW) % SLOTS];
    i = samples_seen;
    abs_total = abs_total - abs_dist(old_first, 0);
    diff_total = diff_total - abs_dist(old_first, old_pred);
    abs_total = abs_total + abs_dist(s, 0);
    diff_total = diff_total + abs_dist(s, prev);
    win_mem[p] = s;
    win_ptr = (p + 1) % SLOTS;
    if (samples_seen < COUNT_MAX) samples_seen++;
    valid = (i + 1 >= WINDOW);
    feat = 0;
    r.phase = PhaseFill;
    if (valid) begin
      feat = abs_total + cfg.diff_gain * diff_total;
      if (feat > FEAT_MAX) feat = FEAT_MAX;
      if (i + 1 >= cfg.learn_length) begin
        t = learn_total >> cfg.learn_shift;
        need = (cfg.pre_count > cfg.trigger_count) ? cfg.pre_count : cfg.trigger_count;
        r.phase = PhaseDetect;
        thr_level = 32'((t > THR_MAX) ? THR_MAX : t);
        r.threshold = ThrW'(thr_level);
        if (feat >= thr_level) begin
          if (run_len < RUN_MAX) run_len++;
        end else begin
          run_len = 0;
        end
        if (!rec_on && run_len >= 1 && run_len >= need) begin
          r.event_res = 1'b1;
          rec_on = 1'b1;
        end
        if (rec_on && feat <= (thr_level >> 1)) rec_on = 1'b0;
      end else begin
        r.phase = PhaseLearn;
        learn_total = learn_total + feat;
        if (learn_total > LEARN_MAX) learn_total = LEARN_MAX;
      end
    end
    r.feature = FeatW'(feat);
    r.feature_valid = valid;
    r.run_length = RunW'(run_len);
    r.recording = rec_on;
    return r;
  endfunction

  function automatic logic [DataW-1:0] register_image(input logic [RegIdxW-1:0] idx);
    case (idx)
      RegLearnLength:  return DataW'(cfg.learn_length);
      RegPreCount:     return DataW'(cfg.pre_count);
      RegTriggerCount: return DataW'(cfg.trigger_count);
      RegDiffGain:     return DataW'(cfg.diff_gain);
      RegLearnShift:   return DataW'(cfg.learn_shift);
      default:         return '0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic logic [SampleW-1:0] noise(input int amp);
    int v;
    v = int'($urandom_range(0, 2 * amp)) - amp;
    return v[SampleW-1:0];
  endfunction

  function automatic logic [SampleW-1:0] strong_sample();
    int v;
    v = int'($urandom_range(1000, 32767));
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[SampleW-1:0];
  endfunction

  function automatic logic [DataW-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return $urandom_range(100, 65535);
    return $urandom_range(1, 40);
  endfunction

  // APB write, then read back
  task automatic write_register(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegLearnLength:  cfg.learn_length = value[CntW-1:0];
      RegPreCount:     cfg.pre_count = value[RunW-1:0];
      RegTriggerCount: cfg.trigger_count = value[RunW-1:0];
      RegDiffGain:     cfg.diff_gain = value[GainW-1:0];
      RegLearnShift:   cfg.learn_shift = value[ShiftW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    if (idx != RegUnused) begin
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      rd = prdata;
      @(posedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
      check_field("prdata", register_image(idx), rd);
      @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input logic [SampleW-1:0] s);
    int gap;
    trig_beat_t beat;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    beat = step_trigger(int'($signed(s)));
    expected_beats.push_back(beat);
    recent_feature = beat.feature;
  endtask

  // stop sending and let every outstanding beat come back
  task automatic pause_stream();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic test_short_learning();
    int k;
    pause_stream();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_register(RegLearnLength, 2);
    write_register(RegPreCount, 0);
    write_register(RegTriggerCount, 0);
    write_register(RegDiffGain, 0);
    write_register(RegLearnShift, 0);
    write_register(RegUnused, 32'hFFFF_FFFF);
    // zero threshold: first valid beat triggers and stops at once
    for (k = 0; k < 66; k++) send_beat('0);
    for (k = 0; k < 10; k++) send_beat((k % 2 == 0) ? 16'h7FFF : 16'h8000);
    for (k = 0; k < 70; k++) send_beat('0);
  endtask

  task automatic test_threshold_saturation();
    int k;
    pause_stream();
    write_register(RegLearnLength, 32'(samples_seen + 1 + 40));
    write_register(RegDiffGain, 255);
    write_register(RegLearnShift, 0);
    write_register(RegPreCount, 65535);
    write_register(RegTriggerCount, 1);
    for (k = 0; k < 120; k++) send_beat((k % 2 == 0) ? 16'h7FFF : 16'h8000);
    send_beat(16'h0001);
    send_beat(16'hFFFF);
    send_beat(16'h5555);
    send_beat(16'hAAAA);
  endtask

  task automatic test_backpressure();
    int k;
    pause_stream();
    write_register(RegLearnShift, 31);
    write_register(RegPreCount, 3);
    write_register(RegTriggerCount, 2);
    rx_hold_id++;
    for (k = 0; k < 64; k++) send_beat(16'($urandom_range(0, 65535)));
    pause_stream();
  endtask

  task automatic test_random_episodes();
    int beats, amp_q, amp_b, n_seg, seg, len, k, sh;
    longint unsigned target;
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      pause_stream();
      write_register(RegPreCount, rand_count());
      write_register(RegTriggerCount, rand_count());
      write_register(RegDiffGain, $urandom_range(0, 255));
      amp_q = $urandom_range(4, 1500);
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(30, 150);
        write_register(RegLearnLength, 32'(samples_seen + 1 + len));
        for (k = 0; k < len; k++) send_beat(noise(amp_q));
        beats += len;
        pause_stream();
        // pick a shift that puts the threshold near the quiet level
        target = (recent_feature == 0) ? 1 : recent_feature;
        sh = 0;
        while (sh < 31 && (learn_total >> (sh + 1)) >= target) sh++;
        sh = sh + int'($urandom_range(0, 2)) - 1;
        if (sh < 0) sh = 0;
        if (sh > 31) sh = 31;
        write_register(RegLearnShift, sh);
      end
      n_seg = $urandom_range(2, 6);
      for (seg = 0; seg < n_seg; seg++) begin
        len = $urandom_range(5, 90);
        amp_b = amp_q * int'($urandom_range(2, 10));
        if (amp_b > 32767) amp_b = 32767;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send_beat(16'($urandom_range(0, 65535)));
          else if (seg % 2 == 1) send_beat(noise(amp_b));
          else send_beat(noise(amp_q));
        end
        beats += len;
      end
    end
  endtask

  task automatic test_no_idle_stretch();
    int k;
    pause_stream();
    write_register(RegLearnShift, 31);
    write_register(RegPreCount, 65535);
    write_register(RegTriggerCount, 1);
    write_register(RegDiffGain, $urandom_range(0, 255));
    // long stretch without idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (k = 0; k < LONG_RUN_BEATS; k++) send_beat(strong_sample());
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_id != rx_hold_seen) begin
      rx_hold_seen = rx_hold_id;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en) begin
      out_ready_i <= ($urandom_range(0, 99) >= 25);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_beat.feature = feature_o;
      got_beat.feature_valid = feature_valid_o;
      got_beat.phase = phase_o;
      got_beat.threshold = threshold_o;
      got_beat.run_length = run_length_o;
      got_beat.event_res = event_res_o;
      got_beat.recording = recording_o;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $error("result beat with nothing expected");
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("feature", want_beat.feature, got_beat.feature);
        check_field("feature_valid", want_beat.feature_valid, got_beat.feature_valid);
        check_field("phase", want_beat.phase, got_beat.phase);
        check_field("threshold", want_beat.threshold, got_beat.threshold);
        check_field("run_length", want_beat.run_length, got_beat.run_length);
        check_field("event_res", want_beat.event_res, got_beat.event_res);
        check_field("recording", want_beat.recording, got_beat.recording);
      end
    end
  end

  initial begin
    int k;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    sample_i <= '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    recent_feature = 0;
    cfg.learn_length = LearnLengthRst;
    cfg.pre_count = PreCountRst;
    cfg.trigger_count = TriggerCountRst;
    cfg.diff_gain = DiffGainRst;
    cfg.learn_shift = LearnShiftRst;
    for (k = 0; k < SLOTS; k++) win_mem[k] = 0;
    win_ptr = 0;
    abs_total = 0;
    diff_total = 0;
    learn_total = 0;
    samples_seen = 0;
    thr_level = 0;
    run_len = 0;
    rec_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_learning();
    test_threshold_saturation();
    test_backpressure();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_episodes();
    test_no_idle_stretch();

    in_valid_i <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && expected_beats.size() != 0; k++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      mismatch_count++;
      $error("%0d expected beats never arrived", expected_beats.size());
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### seismic_event_trigger.f
+incdir+src
src/set_pkg.sv
src/set_cfg.sv
src/set_window.sv
src/set_detect.sv
src/seismic_event_trigger.sv
sim/seismic_event_trigger_tb.sv
